[rtl/core/lbo_pkg.sv]
// shared types, register map and fixed-point helpers for the layer blender
package lbo_pkg;

  // apb register map
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] RegOpacity   = 2'd0;
  localparam logic [RegIdxW-1:0] RegBlendMode = 2'd1;
  localparam logic [RegIdxW-1:0] RegVisible   = 2'd2;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WeightW = 16;

  localparam logic [ByteW-1:0] OpacityReset = 8'd255;
  localparam logic [ByteW-1:0] ByteMax      = 8'd255;
  localparam logic [63:0]      ByteRound    = 64'd127;

  // 2.30 fixed point unity
  localparam logic [63:0] QOne = 64'd1 << 30;

  typedef enum logic [1:0] {
    BlendNormal   = 2'd0,
    BlendMultiply = 2'd1,
    BlendScreen   = 2'd2,
    BlendAdd      = 2'd3
  } blend_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] opacity;
    blend_mode_e      mode;
    logic             visible;
  } cfg_t;

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + (QOne >> 1)) >> 30;
  endfunction

  function automatic logic [63:0] qpow5(logic [63:0] y);
    logic [63:0] y2;
    y2 = qmul(y, y);
    return qmul(qmul(y2, y2), y);
  endfunction

  function automatic logic [63:0] qpow12(logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = qmul(y, y);
    y4 = qmul(y2, y2);
    return qmul(qmul(y4, y4), y4);
  endfunction

  // largest y in [0, 1] with y^5 (or y^12) not above target, table build only
  function automatic logic [63:0] qroot(logic [63:0] target, logic twelve);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    lo = '0;
    hi = QOne;
    for (int it = 0; it < 32; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        p   = twelve ? qpow12(mid) : qpow5(mid);
        if (p <= target) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // floor(x / (2^n - 1)) for x below 2^(3n): shift estimate plus one correction
  function automatic logic [63:0] div_m1(logic [63:0] x, int unsigned n);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] back;
    m    = (64'd1 << n) - 64'd1;
    q    = (x + (x >> n) + (x >> (2 * n)) + 64'd1) >> n;
    back = (q << n) - q;
    if (back > x) q = q - 64'd1;
    else if ((x - back) >= m) q = q + 64'd1;
    return q;
  endfunction

endpackage

[rtl/core/lbo_cfg.sv]
// apb register file: opacity, blend mode and visibility
module lbo_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lbo_pkg::AddrW-1:0] paddr,
  input  logic [lbo_pkg::DataW-1:0] pwdata,
  output logic [lbo_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output lbo_pkg::cfg_t             cfg_o
);
  import lbo_pkg::*;

  cfg_t               cfg_q;
  logic               wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.opacity <= OpacityReset;
      cfg_q.mode    <= BlendNormal;
      cfg_q.visible <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        RegOpacity:   cfg_q.opacity <= pwdata[ByteW-1:0];
        RegBlendMode: cfg_q.mode    <= blend_mode_e'(pwdata[1:0]);
        RegVisible:   cfg_q.visible <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegOpacity:   prdata = DataW'(cfg_q.opacity);
      RegBlendMode: prdata = DataW'(cfg_q.mode);
      RegVisible:   prdata = DataW'(cfg_q.visible);
      default:      prdata = '0;
    endcase
  end

endmodule

[rtl/core/lbo_front.sv]
// front stages: request capture, alpha scaling, srgb decode, alpha weights
module lbo_front #(
  parameter int unsigned LINEAR_BITS = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  lbo_pkg::cfg_t                                 cfg_i,
  input  logic                                          valid_i,
  input  logic [3:0][lbo_pkg::ByteW-1:0]                src_px_i,
  input  logic [3:0][lbo_pkg::ByteW-1:0]                dst_px_i,
  output logic                                          valid_o,
  output logic [2:0][LINEAR_BITS-1:0]                   s_lin_o,
  output logic [2:0][LINEAR_BITS-1:0]                   d_lin_o,
  output logic [lbo_pkg::WeightW-1:0]                   wsa_o,
  output logic [lbo_pkg::WeightW-1:0]                   dainv_o,
  output logic [lbo_pkg::WeightW-1:0]                   a_sum_o,
  output logic                                          pass_o,
  output logic [3:0][lbo_pkg::ByteW-1:0]                dst_px_o
);
  import lbo_pkg::*;

  localparam logic [63:0] LMax = (64'd1 << LINEAR_BITS) - 64'd1;

  // srgb to linear, 2.30 math with the power taken by root search
  function automatic logic [63:0] dec_entry(int unsigned i);
    logic [63:0] ii;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] t4;
    logic [63:0] t12;
    ii = 64'(i);
    if (ii <= 64'd10) begin
      y = ((ii << 30) * 64'd100) / 64'd329460;
    end else begin
      t = ((ii * 64'd1000 + 64'd14025) << 30) / 64'd269025;
      if (t > QOne) t = QOne;
      t4  = qmul(qmul(t, t), qmul(t, t));
      t12 = qmul(qmul(t4, t4), t4);
      y   = qroot(t12, 1'b0);
    end
    y = (y * LMax + (QOne >> 1)) >> 30;
    if (y > LMax) y = LMax;
    return y;
  endfunction

  logic [LINEAR_BITS-1:0] dec_rom [256];

  for (genvar i = 0; i < 256; i++) begin : g_dec
    localparam logic [63:0] Entry = dec_entry(i);
    assign dec_rom[i] = Entry[LINEAR_BITS-1:0];
  end

  // stage 0: request capture
  logic                  v0_q;
  logic [3:0][ByteW-1:0] src0_q;
  logic [3:0][ByteW-1:0] dst0_q;
  // stage 1: scaled alpha and decode
  logic                         v1_q;
  logic [ByteW-1:0]             sa1_q;
  logic [2:0][LINEAR_BITS-1:0]  s1_q;
  logic [2:0][LINEAR_BITS-1:0]  d1_q;
  logic [3:0][ByteW-1:0]        dst1_q;
  // stage 2: weights
  logic                         v2_q;
  logic [2:0][LINEAR_BITS-1:0]  s2_q;
  logic [2:0][LINEAR_BITS-1:0]  d2_q;
  logic [WeightW-1:0]           wsa2_q;
  logic [WeightW-1:0]           dainv2_q;
  logic [WeightW-1:0]           a2_q;
  logic                         pass2_q;
  logic [3:0][ByteW-1:0]        dst2_q;

  logic [63:0]        sa_full;
  logic [ByteW-1:0]   inv;
  logic [WeightW-1:0] wsa_d;
  logic [WeightW-1:0] dainv_d;

  assign sa_full = div_m1(64'(WeightW'(src0_q[3]) * WeightW'(cfg_i.opacity)) + ByteRound,
                          ByteW);
  assign inv     = ByteMax - sa1_q;
  assign wsa_d   = WeightW'(sa1_q) * WeightW'(ByteMax);
  assign dainv_d = WeightW'(dst1_q[3]) * WeightW'(inv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    src0_q <= src_px_i;
    dst0_q <= dst_px_i;

    sa1_q  <= sa_full[ByteW-1:0];
    dst1_q <= dst0_q;
    for (int c = 0; c < 3; c++) begin
      s1_q[c] <= dec_rom[src0_q[c]];
      d1_q[c] <= dec_rom[dst0_q[c]];
    end

    s2_q     <= s1_q;
    d2_q     <= d1_q;
    wsa2_q   <= wsa_d;
    dainv2_q <= dainv_d;
    a2_q     <= wsa_d + dainv_d;
    pass2_q  <= !cfg_i.visible || (sa1_q == '0);
    dst2_q   <= dst1_q;
  end

  assign valid_o  = v2_q;
  assign s_lin_o  = s2_q;
  assign d_lin_o  = d2_q;
  assign wsa_o    = wsa2_q;
  assign dainv_o  = dainv2_q;
  assign a_sum_o  = a2_q;
  assign pass_o   = pass2_q;
  assign dst_px_o = dst2_q;

endmodule

[rtl/core/lbo_divu.sv]
// pipelined restoring divider, one quotient bit per stage
module lbo_divu #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16,
  parameter int unsigned Q_W   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o
);

  logic [Q_W-1:0]   valid_q;
  logic [NUM_W-1:0] rem_q  [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W];
  logic [Q_W-1:0]   quot_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned Sh = Q_W - 1 - k;

    logic             v_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quot_in;
    logic [NUM_W-1:0] trial;
    logic             ge;
    logic [Q_W-1:0]   quot_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    assign trial = NUM_W'(den_in) << Sh;
    assign ge    = rem_in >= trial;

    always_comb begin
      quot_d     = quot_in;
      quot_d[Sh] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? (rem_in - trial) : rem_in;
      den_q[k]  <= den_in;
      quot_q[k] <= quot_d;
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign quot_o  = quot_q[Q_W-1];

endmodule

[rtl/core/lbo_chan.sv]
// one colour channel: blend mode, over weighting, divide and srgb encode
module lbo_chan #(
  parameter int unsigned LINEAR_BITS       = 16,
  parameter int unsigned ENCODE_INDEX_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lbo_pkg::blend_mode_e         mode_i,
  input  logic                         valid_i,
  input  logic [LINEAR_BITS-1:0]       s_i,
  input  logic [LINEAR_BITS-1:0]       d_i,
  input  logic [lbo_pkg::WeightW-1:0]  wsa_i,
  input  logic [lbo_pkg::WeightW-1:0]  dainv_i,
  input  logic [lbo_pkg::WeightW-1:0]  a_i,
  output logic                         valid_o,
  output logic [lbo_pkg::ByteW-1:0]    code_o
);
  import lbo_pkg::*;

  localparam int unsigned ProdW   = 2 * LINEAR_BITS;
  localparam int unsigned TermW   = LINEAR_BITS + WeightW;
  localparam int unsigned MulW    = LINEAR_BITS + ENCODE_INDEX_BITS;
  localparam int unsigned EncSize = 1 << ENCODE_INDEX_BITS;
  localparam logic [63:0] LMax    = (64'd1 << LINEAR_BITS) - 64'd1;
  localparam logic [63:0] EncMax  = (64'd1 << ENCODE_INDEX_BITS) - 64'd1;
  localparam logic [63:0] EncDen  = EncMax * 64'd200;

  // linear to srgb code for index k, root taken by search in 2.30
  function automatic logic [63:0] enc_entry(int unsigned k);
    logic [63:0] kk;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    logic [63:0] am;
    logic [63:0] cm;
    logic [63:0] sl;
    kk = 64'(k);
    if (kk * 64'd10000000 <= 64'd31308 * EncMax) begin
      b = (kk * 64'd658920 + EncMax * 64'd100) / EncDen;
    end else begin
      x  = (kk << 30) / EncMax;
      x2 = qmul(x, x);
      y  = qroot(qmul(qmul(x2, x2), x), 1'b1);
      am = y * 64'd1055;
      cm = 64'd55 * QOne;
      sl = (am > cm) ? (am - cm) / 64'd1000 : 64'd0;
      b  = (sl * 64'd255 + (QOne >> 1)) >> 30;
    end
    if (b > 64'd255) b = 64'd255;
    return b;
  endfunction

  logic [ByteW-1:0] enc_rom [EncSize];

  for (genvar k = 0; k < EncSize; k++) begin : g_enc
    localparam logic [63:0] Code = enc_entry(k);
    assign enc_rom[k] = Code[ByteW-1:0];
  end

  // stage 1: s times d
  logic                   v1_q;
  logic [LINEAR_BITS-1:0] s1_q;
  logic [LINEAR_BITS-1:0] d1_q;
  logic [ProdW-1:0]       prod1_q;
  logic [WeightW-1:0]     wsa1_q;
  logic [WeightW-1:0]     dainv1_q;
  logic [WeightW-1:0]     a1_q;
  // stage 2: mixed source colour
  logic                   v2_q;
  logic [LINEAR_BITS-1:0] smix2_q;
  logic [LINEAR_BITS-1:0] d2_q;
  logic [WeightW-1:0]     wsa2_q;
  logic [WeightW-1:0]     dainv2_q;
  logic [WeightW-1:0]     a2_q;
  // stage 3: weighted terms
  logic                   v3_q;
  logic [TermW-1:0]       t1_q;
  logic [TermW-1:0]       t2_q;
  logic [WeightW-1:0]     a3_q;
  // stage 4: rounded numerator
  logic                   v4_q;
  logic [TermW-1:0]       num4_q;
  logic [WeightW-1:0]     a4_q;
  // after divide
  logic                         vq;
  logic [LINEAR_BITS-1:0]       quot;
  logic                         v5_q;
  logic [MulW-1:0]              mul5_q;
  logic                         v6_q;
  logic [ENCODE_INDEX_BITS-1:0] idx6_q;
  logic                         v7_q;
  logic [ByteW-1:0]             code7_q;

  logic [63:0]            prod_rnd;
  logic [LINEAR_BITS-1:0] prodr;
  logic [LINEAR_BITS:0]   sum;
  logic [LINEAR_BITS:0]   diff;
  logic [LINEAR_BITS-1:0] smix_d;
  logic [63:0]            idx_full;
  logic [ENCODE_INDEX_BITS-1:0] idx_d;

  assign prod_rnd = div_m1(64'(prod1_q) + (LMax >> 1), LINEAR_BITS);
  assign prodr    = prod_rnd[LINEAR_BITS-1:0];
  assign sum      = (LINEAR_BITS + 1)'(s1_q) + (LINEAR_BITS + 1)'(d1_q);
  assign diff     = sum - (LINEAR_BITS + 1)'(prodr);

  always_comb begin
    case (mode_i)
      BlendNormal:   smix_d = s1_q;
      BlendMultiply: smix_d = prodr;
      BlendScreen:   smix_d = diff[LINEAR_BITS-1:0];
      BlendAdd:      smix_d = sum[LINEAR_BITS] ? '1 : sum[LINEAR_BITS-1:0];
      default:       smix_d = s1_q;
    endcase
  end

  lbo_divu #(
    .NUM_W (TermW),
    .DEN_W (WeightW),
    .Q_W   (LINEAR_BITS)
  ) u_divu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (num4_q),
    .den_i   (a4_q),
    .valid_o (vq),
    .quot_o  (quot)
  );

  // quotient width already caps the colour at one
  assign idx_full = div_m1(64'(mul5_q), LINEAR_BITS);
  assign idx_d    = (idx_full > EncMax) ? EncMax[ENCODE_INDEX_BITS-1:0]
                                        : idx_full[ENCODE_INDEX_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= vq;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s_i;
    d1_q     <= d_i;
    prod1_q  <= ProdW'(s_i) * ProdW'(d_i);
    wsa1_q   <= wsa_i;
    dainv1_q <= dainv_i;
    a1_q     <= a_i;

    smix2_q  <= smix_d;
    d2_q     <= d1_q;
    wsa2_q   <= wsa1_q;
    dainv2_q <= dainv1_q;
    a2_q     <= a1_q;

    t1_q <= TermW'(smix2_q) * TermW'(wsa2_q);
    t2_q <= TermW'(d2_q) * TermW'(dainv2_q);
    a3_q <= a2_q;

    num4_q <= t1_q + t2_q + TermW'(a3_q >> 1);
    a4_q   <= a3_q;

    mul5_q  <= MulW'(quot) * MulW'(EncMax) + MulW'(LMax >> 1);
    idx6_q  <= idx_d;
    code7_q <= enc_rom[idx6_q];
  end

  assign valid_o = v7_q;
  assign code_o  = code7_q;

endmodule

[rtl/core/layer_blend_over_srgb.sv]
// top level: srgb layer pixel composited over a destination pixel
//
// usage
//   request channel: drive the eight source/destination bytes and pulse start;
//   a request is taken at every rising edge with start high and busy low.
//   busy stays low, so one pixel can enter every cycle with no gaps.
//   result channel: done_o is high for exactly one cycle per request, with
//   out_r/g/b/a and changed_o valid in that same cycle; results come back in
//   request order and the receiver has no way to hold them off.
//   throughput is one pixel per clock. the depth comes from the quotient
//   divider, one bit per stage (LINEAR_BITS stages), plus eleven registers of
//   capture, decode, weighting, encode and output, the first loaded by the
//   request edge.
//   config: apb registers opacity (0x0), blend mode (0x4), visible (0x8);
//   write only while no pixel is in flight.
//   reset: all valid bits clear, registers return to opacity 255, normal mode,
//   layer visible; no clearing pass, the first request may follow reset.
module layer_blend_over_srgb #(
  parameter int unsigned LINEAR_BITS       = 16,
  parameter int unsigned ENCODE_INDEX_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lbo_pkg::AddrW-1:0] paddr,
  input  logic [lbo_pkg::DataW-1:0] pwdata,
  output logic [lbo_pkg::DataW-1:0] prdata,
  output logic                      pready,
  // request channel
  input  logic                      start,
  output logic                      busy,
  input  logic [7:0]                src_r_i,
  input  logic [7:0]                src_g_i,
  input  logic [7:0]                src_b_i,
  input  logic [7:0]                src_a_i,
  input  logic [7:0]                dst_r_i,
  input  logic [7:0]                dst_g_i,
  input  logic [7:0]                dst_b_i,
  input  logic [7:0]                dst_a_i,
  // result channel
  output logic                      done_o,
  output logic [7:0]                out_r_o,
  output logic [7:0]                out_g_o,
  output logic [7:0]                out_b_o,
  output logic [7:0]                out_a_o,
  output logic                      changed_o
);
  import lbo_pkg::*;

  // matches the stage count inside each colour channel
  localparam int unsigned ChanLat = LINEAR_BITS + 7;
  // request edge to the edge that takes the result
  localparam int unsigned Latency = LINEAR_BITS + 11;

  // side data that rides alongside the colour channels
  typedef struct packed {
    logic                  valid;
    logic                  pass;
    logic [3:0][ByteW-1:0] dst;
    logic [ByteW-1:0]      out_a;
  } side_t;

  cfg_t                         cfg;
  logic                         accept;
  logic [3:0][ByteW-1:0]        src_px;
  logic [3:0][ByteW-1:0]        dst_px;

  logic                         f_valid;
  logic [2:0][LINEAR_BITS-1:0]  f_s;
  logic [2:0][LINEAR_BITS-1:0]  f_d;
  logic [WeightW-1:0]           f_wsa;
  logic [WeightW-1:0]           f_dainv;
  logic [WeightW-1:0]           f_a;
  logic                         f_pass;
  logic [3:0][ByteW-1:0]        f_dst;

  logic [2:0]                   chan_valid;
  logic [2:0][ByteW-1:0]        code;

  side_t                        side_d;
  side_t                        side_q [ChanLat];
  side_t                        last;
  logic [63:0]                  out_a_full;

  logic                         done_q;
  logic [3:0][ByteW-1:0]        out_q;
  logic                         changed_q;

  // never stalls: every pixel slot moves one stage per clock
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign src_px = {src_a_i, src_b_i, src_g_i, src_r_i};
  assign dst_px = {dst_a_i, dst_b_i, dst_g_i, dst_r_i};

  lbo_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // capture, effective alpha, srgb decode and the two alpha weights
  lbo_front #(
    .LINEAR_BITS (LINEAR_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (accept),
    .src_px_i (src_px),
    .dst_px_i (dst_px),
    .valid_o  (f_valid),
    .s_lin_o  (f_s),
    .d_lin_o  (f_d),
    .wsa_o    (f_wsa),
    .dainv_o  (f_dainv),
    .a_sum_o  (f_a),
    .pass_o   (f_pass),
    .dst_px_o (f_dst)
  );

  // one datapath per colour, all three advance in lock step
  for (genvar c = 0; c < 3; c++) begin : g_chan
    lbo_chan #(
      .LINEAR_BITS       (LINEAR_BITS),
      .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (cfg.mode),
      .valid_i (f_valid),
      .s_i     (f_s[c]),
      .d_i     (f_d[c]),
      .wsa_i   (f_wsa),
      .dainv_i (f_dainv),
      .a_i     (f_a),
      .valid_o (chan_valid[c]),
      .code_o  (code[c])
    );
  end

  // result alpha rounded to nearest, A / 255 with rounding
  assign out_a_full = div_m1(64'(f_a) + ByteRound, ByteW);

  always_comb begin
    side_d.valid = f_valid;
    side_d.pass  = f_pass;
    side_d.dst   = f_dst;
    side_d.out_a = out_a_full[ByteW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ChanLat; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      side_q[0] <= side_d;
      for (int k = 1; k < ChanLat; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign last = side_q[ChanLat-1];

  // output register: pass-through picks the destination bytes untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      out_q[c] <= last.pass ? last.dst[c] : code[c];
    end
    out_q[3]  <= last.pass ? last.dst[3] : last.out_a;
    changed_q <= !last.pass;
  end

  assign done_o    = done_q;
  assign out_r_o   = out_q[0];
  assign out_g_o   = out_q[1];
  assign out_b_o   = out_q[2];
  assign out_a_o   = out_q[3];
  assign changed_o = changed_q;

  // colour channels and the side line must stay aligned
  a_chan_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_valid == {3{last.valid}})
    else $error("colour channel valid out of step with side data");

  // every request yields a result after the fixed latency
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("request did not produce a result on time");

  // no result without a matching request
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result strobe without a request");

  // a blended pixel always has nonzero effective alpha
  a_blend_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && changed_o) |-> (out_a_o != 8'd0))
    else $error("blended result with zero alpha");

endmodule

[bench/tb_top.sv]
// self-checking testbench for the srgb layer blender with apb configuration
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lbo_pkg::*;

  localparam int unsigned LinBits = 16;
  localparam int unsigned EncBits = 12;
  localparam longint unsigned LinMax = (64'd1 << LinBits) - 1;
  localparam longint unsigned EncMax = (64'd1 << EncBits) - 1;
  localparam longint unsigned Unity = 64'd1 << 30;
  localparam int unsigned Latency = LinBits + 10;
  localparam int unsigned StallLimit = 4000;

  typedef struct packed {
    logic [7:0] r, g, b, a;
    logic       changed;
  } pixel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [7:0] src_r = '0, src_g = '0, src_b = '0, src_a = '0;
  logic [7:0] dst_r = '0, dst_g = '0, dst_b = '0, dst_a = '0;
  logic done_o, changed_o;
  logic [7:0] out_r_o, out_g_o, out_b_o, out_a_o;

  layer_blend_over_srgb dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .src_r_i(src_r), .src_g_i(src_g), .src_b_i(src_b), .src_a_i(src_a),
    .dst_r_i(dst_r), .dst_g_i(dst_g), .dst_b_i(dst_b), .dst_a_i(dst_a),
    .done_o, .out_r_o, .out_g_o, .out_b_o, .out_a_o, .changed_o
  );

  initial forever #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor: transfer curves in 2.30 fixed point, built once at time zero
  // ---------------------------------------------------------------------------
  longint unsigned to_linear[256];
  logic [7:0]      to_gamma[1 << EncBits];
  logic [7:0]      shadow_opacity = 8'd255;
  blend_mode_e     shadow_mode = BlendNormal;
  logic            shadow_visible = 1'b1;

  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    return (a * b + (Unity >> 1)) >> 30;
  endfunction

  // largest y in [0,1] whose 5th (or 12th) power stays at or below goal
  function automatic longint unsigned fx_root(longint unsigned goal, bit twelfth);
    longint unsigned lo, hi, mid, sq, p;
    lo = 0;
    hi = Unity;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      sq = fx_mul(mid, mid);
      if (twelfth) begin
        p = fx_mul(sq, sq);
        p = fx_mul(fx_mul(p, p), p);
      end else begin
        p = fx_mul(fx_mul(sq, sq), mid);
      end
      if (p <= goal) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic build_curves();
    longint unsigned y, t, t4, x, x2, a, s, b;
    for (int i = 0; i < 256; i++) begin
      if (i <= 10) begin
        // linear toe of the srgb curve
        y = ((longint'(i) << 30) * 100) / 329460;
      end else begin
        t = ((longint'(i) * 1000 + 14025) << 30) / 269025;
        if (t > Unity) t = Unity;
        t4 = fx_mul(fx_mul(t, t), fx_mul(t, t));
        y = fx_root(fx_mul(fx_mul(t4, t4), t4), 1'b0);
      end
      y = (y * LinMax + (Unity >> 1)) >> 30;
      to_linear[i] = (y > LinMax) ? LinMax : y;
    end
    for (longint unsigned k = 0; k <= EncMax; k++) begin
      if (k * 10000000 <= 31308 * EncMax) begin
        b = (k * 255 * 1292 * 2 + EncMax * 100) / (EncMax * 200);
      end else begin
        x = (k << 30) / EncMax;
        x2 = fx_mul(x, x);
        y = fx_root(fx_mul(fx_mul(x2, x2), x), 1'b1);
        a = y * 1055;
        s = (a > 55 * Unity) ? (a - 55 * Unity) / 1000 : 0;
        b = (s * 255 + (Unity >> 1)) >> 30;
      end
      to_gamma[k] = (b > 255) ? 8'd255 : b[7:0];
    end
  endtask

  function automatic pixel_out_t composite(logic [7:0] sr, sg, sb, sa_in,
                                           logic [7:0] dr, dg, db, da_in);
    pixel_out_t o;
    longint unsigned sa, da, inv, cov, s, d, prod, v, idx;
    logic [7:0] sc[3], dc[3], res[3];
    sc = '{sr, sg, sb};
    dc = '{dr, dg, db};
    da = da_in;
    sa = (longint'(sa_in) * shadow_opacity + 127) / 255;
    if (!shadow_visible || sa == 0) begin
      // hidden layer or fully transparent after opacity: destination unchanged
      o = '{dr, dg, db, da_in, 1'b0};
      return o;
    end
    inv = 255 - sa;
    cov = sa * 255 + da * inv;
    for (int c = 0; c < 3; c++) begin
      s = to_linear[sc[c]];
      d = to_linear[dc[c]];
      prod = (s * d + LinMax / 2) / LinMax;
      case (shadow_mode)
        BlendMultiply: s = prod;
        BlendScreen:   s = s + d - prod;
        BlendAdd:      s = (s + d > LinMax) ? LinMax : s + d;
        default:       ;
      endcase
      v = (s * sa * 255 + d * da * inv + cov / 2) / cov;
      if (v > LinMax) v = LinMax;
      idx = (v * EncMax + LinMax / 2) / LinMax;
      if (idx > EncMax) idx = EncMax;
      res[c] = to_gamma[idx];
    end
    o = '{res[0], res[1], res[2], 8'((2 * cov + 255) / 510), 1'b1};
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predicts accepted requests, checks every result in order
  // ---------------------------------------------------------------------------
  pixel_out_t pending_pixels[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    pixel_out_t want, got;
    if (rst_ni) begin
      // track register writes the same way the block sees them
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          RegOpacity:   shadow_opacity <= pwdata[7:0];
          RegBlendMode: shadow_mode <= blend_mode_e'(pwdata[1:0]);
          RegVisible:   shadow_visible <= pwdata[0];
          default:      ;
        endcase
      end
      if (start && !busy)
        pending_pixels.push_back(composite(src_r, src_g, src_b, src_a,
                                           dst_r, dst_g, dst_b, dst_a));
      if (done_o) begin
        got = '{out_r_o, out_g_o, out_b_o, out_a_o, changed_o};
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, got);
          error_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (want.r !== got.r)
            $display("%0t: out_r expected %0d actual %0d", $time, want.r, got.r);
          if (want.g !== got.g)
            $display("%0t: out_g expected %0d actual %0d", $time, want.g, got.g);
          if (want.b !== got.b)
            $display("%0t: out_b expected %0d actual %0d", $time, want.b, got.b);
          if (want.a !== got.a)
            $display("%0t: out_a expected %0d actual %0d", $time, want.a, got.a);
          if (want.changed !== got.changed)
            $display("%0t: changed expected %0d actual %0d", $time,
                     want.changed, got.changed);
          if (want !== got) error_count++;
        end
      end
      // watchdog on cycles where nothing moves
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  bit allow_gaps = 1'b1;

  // one pixel request; returns at the edge that took it, or after a random idle burst
  task automatic send_pixel(logic [7:0] sr, sg, sb, sa, dr, dg, db, da);
    bit taken;
    start <= 1'b1;
    src_r <= sr; src_g <= sg; src_b <= sb; src_a <= sa;
    dst_r <= dr; dst_g <= dg; dst_b <= db; dst_a <= da;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    // random idle burst on the request side
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // stop requests and wait for every pixel in flight to come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] opacity, blend_mode_e mode, logic visible);
    drain();
    reg_write(RegOpacity, {$urandom} & 32'hFFFF_FF00 | opacity);
    reg_write(RegBlendMode, {$urandom} & 32'hFFFF_FFFC | mode);
    reg_write(RegVisible, {$urandom} & 32'hFFFF_FFFE | visible);
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha(),
               8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: opaque, normal, visible; extremes of every byte
  task automatic test_reset_defaults();
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd10, 8'd11, 8'd12, 8'd128, 8'd200, 8'd3, 8'd90, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd128, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd200, 8'd100, 8'd50, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // every blend mode on saturated and mid colors
  task automatic test_blend_modes();
    for (int m = 0; m < 4; m++) begin
      set_config(8'd255, blend_mode_e'(m), 1'b1);
      send_pixel(8'd255, 8'd128, 8'd0, 8'd255, 8'd255, 8'd128, 8'd255, 8'd255);
      send_pixel(8'd200, 8'd30, 8'd90, 8'd127, 8'd60, 8'd220, 8'd10, 8'd180);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd64, 8'd255, 8'd255, 8'd255, 8'd0);
    end
  endtask

  // opacity extremes, rounding to zero alpha, hidden layer
  task automatic test_opacity_and_hidden();
    set_config(8'd0, BlendNormal, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd9, 8'd8, 8'd7, 8'd6);
    set_config(8'd1, BlendScreen, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd127, 8'd9, 8'd8, 8'd7, 8'd6);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd128, 8'd9, 8'd8, 8'd7, 8'd6);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd255, 8'd9, 8'd8, 8'd7, 8'd255);
    set_config(8'd255, BlendAdd, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 8'd128, 8'd254, 8'd77);
  endtask

  // random configuration phases with random pixels; tail runs without gaps
  task automatic test_random_stream();
    logic [7:0] op;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0:       op = 8'd255;
        1:       op = 8'd0;
        default: op = 8'($urandom);
      endcase
      set_config(op, blend_mode_e'($urandom_range(0, 3)), $urandom_range(0, 9) != 0);
      if (phase >= 10) allow_gaps = 1'b0;
      repeat (100) send_random_pixel();
    end
    drain();
  endtask

  initial begin
    build_curves();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_blend_modes();
    test_opacity_and_hidden();
    test_random_stream();
    repeat (Latency + 10) @(posedge clk_i);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lbo_pkg.sv
rtl/core/lbo_cfg.sv
rtl/core/lbo_front.sv
rtl/core/lbo_divu.sv
rtl/core/lbo_chan.sv
rtl/core/layer_blend_over_srgb.sv
bench/tb_top.sv
